// ----- rtl/core/four_channel_pcm_clip_mixer_unit_macros.svh -----
// Assertion macros for the four channel PCM clip mixer.
// Expects signals named clock and reset in the including scope.
`ifndef FOUR_CHANNEL_PCM_CLIP_MIXER_UNIT_MACROS_SVH
`define FOUR_CHANNEL_PCM_CLIP_MIXER_UNIT_MACROS_SVH

// Same-cycle implication.
`define FMX_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FMX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must never hold.
`define FMX_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

// ----- rtl/core/fmx_pkg.sv -----
// Shared types and constants of the four channel PCM clip mixer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fmx_pkg;

   localparam int ADDR_BITS      = 19;
   localparam int CHANNELS       = 4;
   localparam int HEADER_BYTES   = 44;
   localparam int CLIP_REGS      = 4;
   localparam int CLIP_IDX_BITS  = $clog2(CLIP_REGS);
   localparam int CH_IDX_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int COUNT_BITS     = $clog2(CHANNELS + 1);

   localparam int OPCODE_BITS    = 2;
   localparam int CH_FIELD_BITS  = 2;
   localparam int LOAD_ADDR_BITS = 19;
   localparam int SAMPLE_BITS    = 8;
   localparam int MASK_BITS      = 4;
   localparam int BASE_BITS      = 19;
   localparam int LEN_BITS       = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 19;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LENGTH_FIRST = CSR_INDEX_BITS'(CLIP_REGS);

   localparam int SAMPLE_BIAS    = 128;
   localparam int SUM_BITS       = 10;
   localparam int RECIP3_MUL     = 683;
   localparam int RECIP3_BITS    = 10;
   localparam int RECIP3_SHIFT   = 11;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OPCODE_BITS-1:0] OPC_LOAD  = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OPC_START = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OPC_STOP  = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OPC_TICK  = 2'd3;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_START,
      OP_STOP,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [CH_IDX_BITS-1:0]    channel;
      logic [ADDR_BITS-1:0]      addr;
      logic [SAMPLE_BITS-1:0]    data;
   } cmd_type;

   typedef struct packed {
      logic [BASE_BITS-1:0] base;
      logic [LEN_BITS-1:0]  length;
   } clip_cfg_type;

   typedef struct packed {
      logic                  idle;
      logic [COUNT_BITS-1:0] mix_count;
   } status_type;

endpackage

// ----- rtl/core/fmx_front.sv -----
// Front end: takes request transfers, decodes them into commands and queues them.
// Depends on fmx_pkg.
`timescale 1ns / 1ps

module fmx_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [fmx_pkg::OPCODE_BITS-1:0]        req_opcode,
   input  logic [fmx_pkg::CH_FIELD_BITS-1:0]      req_channel,
   input  logic [fmx_pkg::LOAD_ADDR_BITS-1:0]     req_load_address,
   input  logic [fmx_pkg::SAMPLE_BITS-1:0]        req_load_data,
   output logic                                   cmd_valid,
   input  logic                                   cmd_ready,
   output fmx_pkg::cmd_type                       cmd
);

   fmx_pkg::cmd_type                 queue_ff [fmx_pkg::QUEUE_DEPTH];
   logic [fmx_pkg::QPTR_BITS-1:0]    wr_ptr_ff;
   logic [fmx_pkg::QPTR_BITS-1:0]    wr_ptr_in;
   logic [fmx_pkg::QPTR_BITS-1:0]    rd_ptr_ff;
   logic [fmx_pkg::QPTR_BITS-1:0]    rd_ptr_in;
   logic [fmx_pkg::QCNT_BITS-1:0]    count_ff;
   logic [fmx_pkg::QCNT_BITS-1:0]    count_in;
   fmx_pkg::cmd_type                 decoded;
   logic                             push;
   logic                             pop;
   logic                             ch_ok;

   always_comb begin
      ch_ok           = {1'b0, req_channel} < (fmx_pkg::CH_FIELD_BITS + 1)'(fmx_pkg::CHANNELS);
      decoded.channel = fmx_pkg::CH_IDX_BITS'(req_channel);
      decoded.addr    = fmx_pkg::ADDR_BITS'(req_load_address);
      decoded.data    = req_load_data;
      case (req_opcode)
         fmx_pkg::OPC_LOAD:  decoded.op = fmx_pkg::OP_LOAD;
         fmx_pkg::OPC_START: decoded.op = ch_ok ? fmx_pkg::OP_START : fmx_pkg::OP_NOP;
         fmx_pkg::OPC_STOP:  decoded.op = ch_ok ? fmx_pkg::OP_STOP : fmx_pkg::OP_NOP;
         fmx_pkg::OPC_TICK:  decoded.op = fmx_pkg::OP_TICK;
         default:            decoded.op = fmx_pkg::OP_NOP;
      endcase
   end

   assign req_ready = (count_ff != fmx_pkg::QCNT_BITS'(fmx_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid & req_ready;
   assign pop       = cmd_valid & cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fmx_pkg::QPTR_BITS'(fmx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fmx_pkg::QPTR_BITS'(fmx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/fmx_back.sv -----
// Back end: executes queued commands, owns the sample memory and channel state,
// scans channels on a tick and mixes the fetched samples. Depends on fmx_pkg.
`timescale 1ns / 1ps

module fmx_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   output logic                                cmd_ready,
   input  fmx_pkg::cmd_type                    cmd,
   input  fmx_pkg::clip_cfg_type               clip_cfg [fmx_pkg::CLIP_REGS],
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fmx_pkg::SAMPLE_BITS-1:0]     rsp_mixed_sample,
   output logic [fmx_pkg::MASK_BITS-1:0]       rsp_playing_mask,
   output fmx_pkg::status_type                 status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MIX
   } state_type;

   localparam int PROD_BITS = fmx_pkg::SUM_BITS + fmx_pkg::RECIP3_BITS;

   logic [fmx_pkg::SAMPLE_BITS-1:0]        mem [2 ** fmx_pkg::ADDR_BITS];
   logic [fmx_pkg::SAMPLE_BITS-1:0]        rd_data_ff;
   logic [fmx_pkg::ADDR_BITS-1:0]          rd_addr;
   logic                                   mem_we;

   state_type                              state_ff, state_in;
   logic [fmx_pkg::CH_IDX_BITS-1:0]        chan_ff, chan_in;
   logic [fmx_pkg::LEN_BITS-1:0]           offset_ff [fmx_pkg::CHANNELS];
   logic [fmx_pkg::LEN_BITS-1:0]           offset_in [fmx_pkg::CHANNELS];
   logic [fmx_pkg::CHANNELS-1:0]           playing_ff, playing_in;
   logic signed [fmx_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   logic [fmx_pkg::COUNT_BITS-1:0]         count_ff, count_in;
   logic                                   rd_pend_ff, rd_pend_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [fmx_pkg::SAMPLE_BITS-1:0]        rsp_sample_ff, rsp_sample_in;
   logic [fmx_pkg::MASK_BITS-1:0]          rsp_mask_ff, rsp_mask_in;

   logic [fmx_pkg::LEN_BITS-1:0]           sel_off;
   logic [fmx_pkg::LEN_BITS-1:0]           sel_len;
   logic [fmx_pkg::LEN_BITS-1:0]           cmd_len;
   logic signed [fmx_pkg::SAMPLE_BITS:0]   centered;
   logic [fmx_pkg::SUM_BITS-1:0]           abs_sum;
   logic [PROD_BITS-1:0]                   prod;
   logic [fmx_pkg::SUM_BITS-1:0]           quot;
   logic [fmx_pkg::SUM_BITS-1:0]           quot_signed;
   logic [fmx_pkg::SAMPLE_BITS-1:0]        mixed;

   function automatic logic [fmx_pkg::LEN_BITS-1:0] data_len(
      input logic [fmx_pkg::LEN_BITS-1:0] len
   );
      return (len > fmx_pkg::LEN_BITS'(fmx_pkg::HEADER_BYTES)) ?
             len - fmx_pkg::LEN_BITS'(fmx_pkg::HEADER_BYTES) : '0;
   endfunction

   assign sel_off = offset_ff[chan_ff];
   assign sel_len = data_len(clip_cfg[fmx_pkg::CLIP_IDX_BITS'(chan_ff)].length);
   assign cmd_len = data_len(clip_cfg[fmx_pkg::CLIP_IDX_BITS'(cmd.channel)].length);
   assign rd_addr = fmx_pkg::ADDR_BITS'(clip_cfg[fmx_pkg::CLIP_IDX_BITS'(chan_ff)].base)
                  + fmx_pkg::ADDR_BITS'(fmx_pkg::HEADER_BYTES)
                  + fmx_pkg::ADDR_BITS'(sel_off);
   assign centered = $signed({1'b0, rd_data_ff})
                   - (fmx_pkg::SAMPLE_BITS + 1)'(fmx_pkg::SAMPLE_BIAS);

   // Truncating divide of the centered sum by the fetch count.
   always_comb begin
      abs_sum = sum_ff[fmx_pkg::SUM_BITS-1] ? fmx_pkg::SUM_BITS'(-sum_ff) :
                fmx_pkg::SUM_BITS'(sum_ff);
      prod    = PROD_BITS'(abs_sum) * PROD_BITS'(fmx_pkg::RECIP3_MUL);
      case (count_ff)
         fmx_pkg::COUNT_BITS'(1): quot = abs_sum;
         fmx_pkg::COUNT_BITS'(2): quot = abs_sum >> 1;
         fmx_pkg::COUNT_BITS'(3): quot = fmx_pkg::SUM_BITS'(prod >> fmx_pkg::RECIP3_SHIFT);
         fmx_pkg::COUNT_BITS'(4): quot = abs_sum >> 2;
         default:                 quot = abs_sum;
      endcase
      quot_signed = sum_ff[fmx_pkg::SUM_BITS-1] ? -quot : quot;
      mixed       = fmx_pkg::SAMPLE_BITS'(quot_signed
                  + fmx_pkg::SUM_BITS'(fmx_pkg::SAMPLE_BIAS));
   end

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      offset_in     = offset_ff;
      playing_in    = playing_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      rd_pend_in    = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_mask_in   = rsp_mask_ff;
      mem_we        = 1'b0;
      cmd_ready     = (state_ff == ST_IDLE);

      if (rd_pend_ff) begin
         sum_in = sum_ff + fmx_pkg::SUM_BITS'(centered);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  fmx_pkg::OP_LOAD: begin
                     mem_we = 1'b1;
                  end
                  fmx_pkg::OP_START: begin
                     offset_in[cmd.channel]  = '0;
                     playing_in[cmd.channel] = (cmd_len != '0);
                  end
                  fmx_pkg::OP_STOP: begin
                     offset_in[cmd.channel]  = '0;
                     playing_in[cmd.channel] = 1'b0;
                  end
                  fmx_pkg::OP_TICK: begin
                     state_in = ST_SCAN;
                     chan_in  = '0;
                     sum_in   = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (playing_ff[chan_ff]) begin
               if (sel_off >= sel_len) begin
                  playing_in[chan_ff] = 1'b0;
               end else begin
                  rd_pend_in         = 1'b1;
                  count_in           = count_ff + 1'b1;
                  offset_in[chan_ff] = sel_off + 1'b1;
                  if (({1'b0, sel_off} + 1'b1) >= {1'b0, sel_len}) begin
                     playing_in[chan_ff] = 1'b0;
                  end
               end
            end
            if (chan_ff == fmx_pkg::CH_IDX_BITS'(fmx_pkg::CHANNELS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (count_ff == '0) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = mixed;
               rsp_mask_in   = fmx_pkg::MASK_BITS'(playing_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd.addr] <= cmd.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_mask_ff   <= rsp_mask_in;
      chan_ff       <= chan_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= '{default: '0};
         playing_ff   <= '0;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         playing_ff   <= playing_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;
   assign rsp_playing_mask = rsp_mask_ff;
   assign status.idle      = (state_ff == ST_IDLE);
   assign status.mix_count = count_ff;

endmodule

// ----- rtl/core/four_channel_pcm_clip_mixer_unit.sv -----
// Four channel PCM clip mixer. Requests (load a sample memory byte, start or stop a
// channel, sample tick) are queued two deep and executed one at a time. A tick reads
// each channel in turn on the single read port of the sample memory, lets the last
// read land in a drain state and divides the sum into the output register in a mix
// state, which waits on an untaken response. A tick on which no channel fetches gives
// no response. A new request is taken while a response waits. The user must write the
// clip registers through the csr port only while the block is idle (not enforced).
//
// Top level: clip registers, front queue and back end, plus assertions.
// Depends on fmx_pkg, fmx_front, fmx_back and the assertion macro header.
`timescale 1ns / 1ps
`include "four_channel_pcm_clip_mixer_unit_macros.svh"

module four_channel_pcm_clip_mixer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fmx_pkg::OPCODE_BITS-1:0]     req_opcode,
   input  logic [fmx_pkg::CH_FIELD_BITS-1:0]   req_channel,
   input  logic [fmx_pkg::LOAD_ADDR_BITS-1:0]  req_load_address,
   input  logic [fmx_pkg::SAMPLE_BITS-1:0]     req_load_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fmx_pkg::SAMPLE_BITS-1:0]     rsp_mixed_sample,
   output logic [fmx_pkg::MASK_BITS-1:0]       rsp_playing_mask,
   input  logic                                csr_we,
   input  logic [fmx_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fmx_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   fmx_pkg::clip_cfg_type  clip_cfg_ff [fmx_pkg::CLIP_REGS];
   fmx_pkg::clip_cfg_type  clip_cfg_in [fmx_pkg::CLIP_REGS];
   fmx_pkg::cmd_type       cmd;
   fmx_pkg::status_type    status;
   logic                   cmd_valid;
   logic                   cmd_ready;
   logic [fmx_pkg::CLIP_IDX_BITS-1:0] csr_clip;

   assign csr_clip = csr_index[fmx_pkg::CLIP_IDX_BITS-1:0];

   always_comb begin
      clip_cfg_in = clip_cfg_ff;
      if (csr_we) begin
         if (csr_index < fmx_pkg::CSR_LENGTH_FIRST) begin
            clip_cfg_in[csr_clip].base = csr_wdata[fmx_pkg::BASE_BITS-1:0];
         end else begin
            clip_cfg_in[csr_clip].length = csr_wdata[fmx_pkg::LEN_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_cfg_ff <= '{default: '0};
      end else begin
         clip_cfg_ff <= clip_cfg_in;
      end
   end

   fmx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_channel      (req_channel),
      .req_load_address (req_load_address),
      .req_load_data    (req_load_data),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd)
   );

   fmx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd),
      .clip_cfg         (clip_cfg_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_playing_mask (rsp_playing_mask),
      .status           (status)
   );

   `FMX_ASSERT_NEXT(a_push_fills_queue, req_valid && req_ready, cmd_valid, "queue lost a transfer")
   `FMX_ASSERT_SAME(a_rsp_needs_fetch, $rose(rsp_valid), $past(status.mix_count) != '0, "response without fetch")
   `FMX_ASSERT_NEVER(a_count_bound, status.mix_count > fmx_pkg::COUNT_BITS'(fmx_pkg::CHANNELS), "fetch count overflow")

endmodule

// ----- bench/pcm_mix_checker.sv -----
// Checker for the four channel PCM clip mixer: watches the request, response and csr ports,
// predicts each tick's mixed sample and playing mask, and compares in order of arrival.
// Depends on fmx_pkg for widths, opcodes and the csr register map.
`timescale 1ns / 1ps

module pcm_mix_checker
   import fmx_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [OPCODE_BITS-1:0]     req_opcode,
   input  logic [CH_FIELD_BITS-1:0]   req_channel,
   input  logic [LOAD_ADDR_BITS-1:0]  req_load_address,
   input  logic [SAMPLE_BITS-1:0]     req_load_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [SAMPLE_BITS-1:0]     rsp_mixed_sample,
   input  logic [MASK_BITS-1:0]       rsp_playing_mask,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   output int                         mismatches,
   output int                         outstanding
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] level;
      logic [MASK_BITS-1:0]   play_mask;
   } mix_result_t;

   logic [SAMPLE_BITS-1:0] sample_mem [int];
   logic [LEN_BITS-1:0]    play_offset [CHANNELS];
   logic                   play_on [CHANNELS];
   logic [BASE_BITS-1:0]   clip_base [CLIP_REGS];
   logic [LEN_BITS-1:0]    clip_len [CLIP_REGS];
   mix_result_t            mix_expected [$];
   int                     fail_total;

   function automatic int clip_data_bytes(int ch);
      if (ch >= CLIP_REGS) return 0;
      return (clip_len[ch] > HEADER_BYTES) ? int'(clip_len[ch]) - HEADER_BYTES : 0;
   endfunction

   task automatic predict_mix();
      int                   sum;
      int                   count;
      int                   limit;
      int                   mixed;
      logic [ADDR_BITS-1:0] addr;
      logic [MASK_BITS-1:0] pmask;
      mix_result_t          res;
      sum   = 0;
      count = 0;
      pmask = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (!play_on[i]) continue;
         limit = clip_data_bytes(i);
         // stop a channel whose clip shrank under its offset, no fetch
         if (int'(play_offset[i]) >= limit) begin
            play_on[i] = 1'b0;
            continue;
         end
         addr = ADDR_BITS'(clip_base[i] + HEADER_BYTES + play_offset[i]);
         if (sample_mem.exists(int'(addr)))
            sum += int'(sample_mem[int'(addr)]) - SAMPLE_BIAS;
         else
            sum -= SAMPLE_BIAS;
         count++;
         play_offset[i] = play_offset[i] + 1'b1;
         if (int'(play_offset[i]) >= limit) play_on[i] = 1'b0;
      end
      if (count == 0) return;
      for (int i = 0; i < CHANNELS && i < MASK_BITS; i++)
         if (play_on[i]) pmask[i] = 1'b1;
      mixed         = sum / count + SAMPLE_BIAS;
      res.level     = mixed[SAMPLE_BITS-1:0];
      res.play_mask = pmask;
      mix_expected.push_back(res);
   endtask

   always @(posedge clock) begin
      mix_result_t want;
      if (reset) begin
         sample_mem.delete();
         mix_expected.delete();
         fail_total = 0;
         for (int i = 0; i < CHANNELS; i++) begin
            play_offset[i] = '0;
            play_on[i]     = 1'b0;
         end
         for (int i = 0; i < CLIP_REGS; i++) begin
            clip_base[i] = '0;
            clip_len[i]  = '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index < CSR_LENGTH_FIRST)
               clip_base[csr_index] = csr_wdata[BASE_BITS-1:0];
            else
               clip_len[csr_index - CSR_LENGTH_FIRST] = csr_wdata[LEN_BITS-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (mix_expected.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("unexpected mix transfer: sample %0d mask %b",
                           rsp_mixed_sample, rsp_playing_mask);
            end else begin
               want = mix_expected.pop_front();
               if (rsp_mixed_sample !== want.level || rsp_playing_mask !== want.play_mask) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("mix mismatch: sample exp %0d got %0d, mask exp %b got %b",
                              want.level, rsp_mixed_sample, want.play_mask, rsp_playing_mask);
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_opcode)
               OPC_LOAD: begin
                  sample_mem[int'(req_load_address)] = req_load_data;
               end
               OPC_START, OPC_STOP: begin
                  if (req_channel < CHANNELS) begin
                     play_offset[req_channel] = '0;
                     play_on[req_channel]     = (req_opcode == OPC_START) &&
                                                (clip_data_bytes(req_channel) > 0);
                  end
               end
               default: begin
                  predict_mix();
               end
            endcase
         end
      end
      mismatches  <= fail_total;
      outstanding <= mix_expected.size();
   end

endmodule

// ----- bench/tb_four_channel_pcm_clip_mixer_unit.sv -----
// Testbench top for the four channel PCM clip mixer: drives requests, csr writes and
// response backpressure, and gives the verdict from the failure count of pcm_mix_checker.
// Depends on fmx_pkg, pcm_mix_checker and four_channel_pcm_clip_mixer_unit.
`timescale 1ns / 1ps

module tb_four_channel_pcm_clip_mixer_unit;
   import fmx_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 650;
   localparam int SETTLE_CYCLES = 24;

   logic                       clock;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [OPCODE_BITS-1:0]     req_opcode       = OPC_LOAD;
   logic [CH_FIELD_BITS-1:0]   req_channel      = '0;
   logic [LOAD_ADDR_BITS-1:0]  req_load_address = '0;
   logic [SAMPLE_BITS-1:0]     req_load_data    = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic [SAMPLE_BITS-1:0]     rsp_mixed_sample;
   logic [MASK_BITS-1:0]       rsp_playing_mask;
   logic                       csr_we           = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata        = '0;

   int   mismatches;
   int   outstanding;
   int   cycle_count = 0;
   int   stall_left  = 0;
   int   sent_items  = 0;
   logic rsp_calm    = 1'b0;
   logic req_calm    = 1'b0;

   // clip settings as last written, and the play position the stimulus keeps legal
   logic [BASE_BITS-1:0]     cfg_base [CLIP_REGS];
   logic [CSR_DATA_BITS-1:0] cfg_word [CLIP_REGS];
   int                       play_pos [CHANNELS];
   logic                     playing  [CHANNELS];
   bit                       loaded   [int];

   four_channel_pcm_clip_mixer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_channel      (req_channel),
      .req_load_address (req_load_address),
      .req_load_data    (req_load_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_playing_mask (rsp_playing_mask),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pcm_mix_checker mix_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_channel      (req_channel),
      .req_load_address (req_load_address),
      .req_load_data    (req_load_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_playing_mask (rsp_playing_mask),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int pick_gap(logic quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // hold off response transfers in random stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!rsp_calm && $urandom_range(0, 99) < 35) begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_gap(1'b0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic int clip_bytes(int ch);
      int len;
      len = int'(cfg_word[ch][LEN_BITS-1:0]);
      return (len > HEADER_BYTES) ? len - HEADER_BYTES : 0;
   endfunction

   task automatic xfer(input logic [OPCODE_BITS-1:0] op, input logic [CH_FIELD_BITS-1:0] ch,
                       input logic [LOAD_ADDR_BITS-1:0] addr, input logic [SAMPLE_BITS-1:0] data);
      int gap;
      int lim;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_channel      <= ch;
      req_load_address <= addr;
      req_load_data    <= data;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      case (op)
         OPC_LOAD: begin
            loaded[int'(addr)] = 1'b1;
         end
         OPC_START, OPC_STOP: begin
            play_pos[ch] = 0;
            playing[ch]  = (op == OPC_START) && (clip_bytes(ch) > 0);
         end
         default: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (!playing[i]) continue;
               lim = clip_bytes(i);
               if (play_pos[i] >= lim) begin
                  playing[i] = 1'b0;
               end else begin
                  play_pos[i]++;
                  if (play_pos[i] >= lim) playing[i] = 1'b0;
               end
            end
         end
      endcase
   endtask

   // before a tick, load every byte it will fetch that was never written
   task automatic issue(input logic [OPCODE_BITS-1:0] op, input logic [CH_FIELD_BITS-1:0] ch,
                        input logic [LOAD_ADDR_BITS-1:0] addr, input logic [SAMPLE_BITS-1:0] data);
      logic [ADDR_BITS-1:0] fetch;
      if (op == OPC_TICK) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (playing[i] && play_pos[i] < clip_bytes(i)) begin
               fetch = ADDR_BITS'(cfg_base[i] + HEADER_BYTES + play_pos[i]);
               if (!loaded.exists(int'(fetch)))
                  xfer(OPC_LOAD, CH_FIELD_BITS'($urandom), fetch, SAMPLE_BITS'($urandom));
            end
         end
      end
      xfer(op, ch, addr, data);
   endtask

   task automatic tick();
      issue(OPC_TICK, CH_FIELD_BITS'($urandom), LOAD_ADDR_BITS'($urandom),
            SAMPLE_BITS'($urandom));
   endtask

   task automatic command(input logic [OPCODE_BITS-1:0] op, input int ch);
      issue(op, CH_FIELD_BITS'(ch), LOAD_ADDR_BITS'($urandom), SAMPLE_BITS'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_clips();
      for (int i = 0; i < CLIP_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_BITS'(i);
         csr_wdata <= cfg_base[i];
         @(posedge clock);
      end
      for (int i = 0; i < CLIP_REGS; i++) begin
         csr_index <= CSR_LENGTH_FIRST + CSR_INDEX_BITS'(i);
         csr_wdata <= cfg_word[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int phase_items;
      int r;
      for (int i = 0; i < CLIP_REGS; i++) begin
         cfg_base[i] = '0;
         cfg_word[i] = '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
         play_pos[i] = 0;
         playing[i]  = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset lengths are empty: start then tick stays silent
      command(OPC_START, 0);
      tick();
      settle();

      cfg_base[0] = 19'd1000;
      cfg_word[0] = 19'd47;
      cfg_base[1] = 19'd524280;
      cfg_word[1] = 19'd65535;
      cfg_base[2] = 19'd3000;
      cfg_word[2] = 19'd44;
      cfg_base[3] = 19'd2000;
      cfg_word[3] = 19'd45;
      program_clips();

      issue(OPC_LOAD, 2'd0, 19'd0, 8'h00);
      issue(OPC_LOAD, 2'd3, 19'd524287, 8'hFF);
      tick();
      issue(OPC_LOAD, 2'd0, 19'd1044, 8'h00);
      issue(OPC_LOAD, 2'd1, 19'd1045, 8'hFF);
      issue(OPC_LOAD, 2'd2, 19'd1046, 8'h81);
      issue(OPC_LOAD, 2'd3, 19'd36, 8'h00);
      issue(OPC_LOAD, 2'd0, 19'd37, 8'hFF);
      issue(OPC_LOAD, 2'd1, 19'd38, 8'h00);
      issue(OPC_LOAD, 2'd2, 19'd2044, 8'h00);
      // empty clip rewinds and stays idle
      command(OPC_START, 2);
      tick();
      command(OPC_START, 0);
      command(OPC_START, 1);
      command(OPC_START, 3);
      // full negative swing, one-byte clip ends, full positive, then negative truncation
      tick();
      tick();
      tick();
      command(OPC_STOP, 1);
      tick();
      command(OPC_START, 0);
      tick();
      settle();
      // shrink clip zero under its offset: next tick stops it without a fetch
      cfg_word[0] = 19'd45;
      program_clips();
      tick();
      settle();

      while (sent_items < RANDOM_ITEMS) begin
         for (int i = 0; i < CLIP_REGS; i++) begin
            r = $urandom_range(0, 7);
            cfg_base[i] = (r == 0) ? '0 : (r == 1) ? '1 : BASE_BITS'($urandom);
            r = $urandom_range(0, 19);
            cfg_word[i][LEN_BITS-1:0] =
               (r == 0) ? 16'd0 :
               (r == 1) ? 16'd44 :
               (r == 2) ? 16'd45 :
               (r == 3) ? 16'd65535 :
               (r < 6)  ? LEN_BITS'($urandom_range(0, 44)) :
               (r < 8)  ? LEN_BITS'($urandom_range(46, 65535)) :
                          LEN_BITS'($urandom_range(45, 140));
            cfg_word[i][CSR_DATA_BITS-1:LEN_BITS] = (CSR_DATA_BITS - LEN_BITS)'($urandom);
         end
         program_clips();
         req_calm    <= ($urandom_range(0, 3) == 0);
         rsp_calm    <= ($urandom_range(0, 3) == 0);
         phase_items  = $urandom_range(60, 110);
         for (int n = 0; n < phase_items && sent_items < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               tick();
            else if (r < 60)
               command(OPC_START, $urandom_range(0, 3));
            else if (r < 66)
               command(OPC_STOP, $urandom_range(0, 3));
            else if (r < 83)
               issue(OPC_LOAD, CH_FIELD_BITS'($urandom_range(0, 3)), LOAD_ADDR_BITS'($urandom),
                     SAMPLE_BITS'($urandom));
            else begin
               r = $urandom_range(0, 3);
               issue(OPC_LOAD, CH_FIELD_BITS'($urandom),
                     LOAD_ADDR_BITS'(cfg_base[r] + HEADER_BYTES + $urandom_range(0, 150)),
                     SAMPLE_BITS'($urandom));
            end
         end
         settle();
      end

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
